// ===== src/pbrgt_pkg.sv =====
package pbrgt_pkg;

    // table size, 1..32
    localparam int MAX_RULES = 32;

    localparam int PIX_W      = 24;
    localparam int WORD_W     = 32;
    localparam int CHAN_W     = 8;
    localparam int SHIFT_W    = 5;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int GRAY_SUM_W = 13;
    // wide enough for any lane number and any rule count
    localparam int LANE_CMP_W = 7;

    // or tree: lanes per group in the first level
    localparam int GRP_LANES = 8;
    localparam int N_GRP     = (MAX_RULES + GRP_LANES - 1) / GRP_LANES;

    // gray weights, sum is divided by 32
    localparam int GRAY_WR     = 11;
    localparam int GRAY_WG     = 16;
    localparam int GRAY_WB     = 5;
    localparam int GRAY_SHIFT  = 5;

    localparam logic [CHAN_W-1:0] BYTE_MASK  = 8'hff;
    localparam logic [WORD_W-1:0] RST_AND    = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] RST_OR     = 32'h0000_0000;
    localparam logic [THR_W-1:0]  RST_THR    = 8'd128;
    localparam logic [PIX_W-1:0]  PIX_BLACK  = 24'h000000;
    localparam logic [PIX_W-1:0]  PIX_WHITE  = 24'hffffff;

    typedef enum logic [1:0] {
        MODE_COLOR = 2'd0,
        MODE_GRAY  = 2'd1,
        MODE_MONO  = 2'd2
    } t_color_mode;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_RULE_COUNT = 3'd2,
        CFG_AND_MASK   = 3'd3,
        CFG_OR_MASK    = 3'd4
    } t_cfg_idx;

endpackage

// ===== src/pixel_bit_remap_with_gray_threshold.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------------
// in        | input     | i_in_valid/o_in_ready  | i_operation, i_pixel_rgb, i_rule_index,
//           |           |                        | i_rule_mask, i_rule_shift, i_rule_left
// out       | output    | o_out_valid/i_out_ready| o_pixel_word
// cfg       | input     | i_cfg_wr_en (no wait)  | i_cfg_index, i_cfg_wdata
//
// one item per clock unless the output stalls; a pixel's result reaches the output
// register through five register stages
// (gray sum, prepare, rule lanes, first or level, final or and masks)
// the rule table sits in flops and needs no clearing pass; reset clears valid bits
// and configuration only
// every stage has its own ready, so a stalled output fills bubbles upstream and
// only backs up the input once all five stages hold items
// a load item writes its table slot as it leaves the prepare stage and then drops out
module pixel_bit_remap_with_gray_threshold (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [pbrgt_pkg::PIX_W-1:0]       i_pixel_rgb,
    input  logic [pbrgt_pkg::IDX_W-1:0]       i_rule_index,
    input  logic [pbrgt_pkg::WORD_W-1:0]      i_rule_mask,
    input  logic [pbrgt_pkg::SHIFT_W-1:0]     i_rule_shift,
    input  logic                              i_rule_left,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pbrgt_pkg::WORD_W-1:0]      o_pixel_word,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [pbrgt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pbrgt_pkg::WORD_W-1:0]      i_cfg_wdata
);

    // configuration registers
    pbrgt_pkg::t_color_mode              r_color_mode;
    logic [pbrgt_pkg::THR_W-1:0]         r_threshold;
    logic [pbrgt_pkg::CNT_W-1:0]         r_rule_count;
    logic [pbrgt_pkg::WORD_W-1:0]        r_and_mask;
    logic [pbrgt_pkg::WORD_W-1:0]        r_or_mask;

    // rule table, one entry per lane
    logic [pbrgt_pkg::WORD_W-1:0]        r_rule_mask  [pbrgt_pkg::MAX_RULES];
    logic [pbrgt_pkg::SHIFT_W-1:0]       r_rule_shift [pbrgt_pkg::MAX_RULES];
    logic                                r_rule_left  [pbrgt_pkg::MAX_RULES];

    // stage a: gray level
    logic                                r_a_valid;
    pbrgt_pkg::t_op                      r_a_op;
    logic [pbrgt_pkg::PIX_W-1:0]         r_a_rgb;
    logic [pbrgt_pkg::CHAN_W-1:0]        r_a_gray;
    logic [pbrgt_pkg::IDX_W-1:0]         r_a_idx;
    logic [pbrgt_pkg::WORD_W-1:0]        r_a_mask;
    logic [pbrgt_pkg::SHIFT_W-1:0]       r_a_shift;
    logic                                r_a_left;

    // stage b: prepared word
    logic                                r_b_valid;
    pbrgt_pkg::t_op                      r_b_op;
    logic [pbrgt_pkg::PIX_W-1:0]         r_b_word;
    logic [pbrgt_pkg::IDX_W-1:0]         r_b_idx;
    logic [pbrgt_pkg::WORD_W-1:0]        r_b_mask;
    logic [pbrgt_pkg::SHIFT_W-1:0]       r_b_shift;
    logic                                r_b_left;

    // stage c: lane results
    logic                                r_c_valid;
    logic [pbrgt_pkg::PIX_W-1:0]         r_c_word;
    logic [pbrgt_pkg::WORD_W-1:0]        r_c_lane [pbrgt_pkg::MAX_RULES];

    // stage d: group results
    logic                                r_d_valid;
    logic [pbrgt_pkg::PIX_W-1:0]         r_d_word;
    logic [pbrgt_pkg::WORD_W-1:0]        r_d_grp [pbrgt_pkg::N_GRP];

    // stage e: output register
    logic                                r_e_valid;
    logic [pbrgt_pkg::WORD_W-1:0]        r_e_word;

    logic                                rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
    logic                                tbl_wr;

    logic [pbrgt_pkg::GRAY_SUM_W-1:0]    n_gray_sum;
    logic [pbrgt_pkg::PIX_W-1:0]         n_prep;
    logic [pbrgt_pkg::WORD_W-1:0]        n_lane [pbrgt_pkg::MAX_RULES];
    logic [pbrgt_pkg::WORD_W-1:0]        n_grp  [pbrgt_pkg::N_GRP];
    logic [pbrgt_pkg::WORD_W-1:0]        n_remap;
    logic [pbrgt_pkg::WORD_W-1:0]        n_word;

    // ready chain, each stage takes a new item when empty or when it moves on
    assign rdy_e = !r_e_valid || i_out_ready;
    assign rdy_d = !r_d_valid || rdy_e;
    assign rdy_c = !r_c_valid || rdy_d;
    assign rdy_b = !r_b_valid || rdy_c;
    assign rdy_a = !r_a_valid || rdy_b;

    assign o_in_ready   = rdy_a;
    assign o_out_valid  = r_e_valid;
    assign o_pixel_word = r_e_word;

    // load items write the table as they leave stage b, so pixels ahead of them
    // have already read the old rules and pixels behind see the new one
    assign tbl_wr = r_b_valid && (r_b_op == pbrgt_pkg::OP_LOAD) && rdy_c;

    // weighted gray sum, constant weights only
    always_comb begin
        n_gray_sum = pbrgt_pkg::GRAY_SUM_W'(i_pixel_rgb[23:16]) * pbrgt_pkg::GRAY_SUM_W'(pbrgt_pkg::GRAY_WR)
                   + pbrgt_pkg::GRAY_SUM_W'(i_pixel_rgb[15:8])  * pbrgt_pkg::GRAY_SUM_W'(pbrgt_pkg::GRAY_WG)
                   + pbrgt_pkg::GRAY_SUM_W'(i_pixel_rgb[7:0])   * pbrgt_pkg::GRAY_SUM_W'(pbrgt_pkg::GRAY_WB);
    end

    // pixel preparation by mode, unused mode passes color through
    always_comb begin
        case (r_color_mode)
            pbrgt_pkg::MODE_GRAY: begin
                n_prep = {r_a_gray, r_a_gray, r_a_gray};
            end
            pbrgt_pkg::MODE_MONO: begin
                n_prep = (r_a_gray < r_threshold) ? pbrgt_pkg::PIX_BLACK : pbrgt_pkg::PIX_WHITE;
            end
            default: begin
                n_prep = r_a_rgb;
            end
        endcase
    end

    // one lane per rule: mask, shift, gate by rule count
    always_comb begin
        logic [pbrgt_pkg::WORD_W-1:0] sel;
        for (int i = 0; i < pbrgt_pkg::MAX_RULES; i++) begin
            sel = {{(pbrgt_pkg::WORD_W - pbrgt_pkg::PIX_W){1'b0}}, r_b_word} & r_rule_mask[i];
            if (pbrgt_pkg::LANE_CMP_W'(i) < pbrgt_pkg::LANE_CMP_W'(r_rule_count)) begin
                n_lane[i] = r_rule_left[i] ? (sel << r_rule_shift[i]) : (sel >> r_rule_shift[i]);
            end else begin
                n_lane[i] = '0;
            end
        end
    end

    // first or level over groups of lanes
    always_comb begin
        for (int g = 0; g < pbrgt_pkg::N_GRP; g++) begin
            n_grp[g] = '0;
        end
        for (int i = 0; i < pbrgt_pkg::MAX_RULES; i++) begin
            n_grp[i / pbrgt_pkg::GRP_LANES] = n_grp[i / pbrgt_pkg::GRP_LANES] | r_c_lane[i];
        end
    end

    // final or level, zero rules pass the prepared word, then the masks
    always_comb begin
        n_remap = '0;
        for (int g = 0; g < pbrgt_pkg::N_GRP; g++) begin
            n_remap = n_remap | r_d_grp[g];
        end
        if (r_rule_count == '0) begin
            n_remap = {{(pbrgt_pkg::WORD_W - pbrgt_pkg::PIX_W){1'b0}}, r_d_word};
        end
        n_word = (n_remap & r_and_mask) | r_or_mask;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_e_valid    <= 1'b0;
            r_color_mode <= pbrgt_pkg::MODE_COLOR;
            r_threshold  <= pbrgt_pkg::RST_THR;
            r_rule_count <= '0;
            r_and_mask   <= pbrgt_pkg::RST_AND;
            r_or_mask    <= pbrgt_pkg::RST_OR;
        end else begin
            if (rdy_a) r_a_valid <= i_in_valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            // load items leave the pipe here
            if (rdy_c) r_c_valid <= r_b_valid && (r_b_op == pbrgt_pkg::OP_PIXEL);
            if (rdy_d) r_d_valid <= r_c_valid;
            if (rdy_e) r_e_valid <= r_d_valid;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pbrgt_pkg::CFG_COLOR_MODE: r_color_mode <= pbrgt_pkg::t_color_mode'(i_cfg_wdata[1:0]);
                    pbrgt_pkg::CFG_THRESHOLD:  r_threshold  <= i_cfg_wdata[pbrgt_pkg::THR_W-1:0];
                    pbrgt_pkg::CFG_RULE_COUNT: r_rule_count <= i_cfg_wdata[pbrgt_pkg::CNT_W-1:0];
                    pbrgt_pkg::CFG_AND_MASK:   r_and_mask   <= i_cfg_wdata;
                    pbrgt_pkg::CFG_OR_MASK:    r_or_mask    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_op    <= pbrgt_pkg::t_op'(i_operation);
            r_a_rgb   <= i_pixel_rgb;
            r_a_gray  <= n_gray_sum[pbrgt_pkg::GRAY_SHIFT +: pbrgt_pkg::CHAN_W];
            r_a_idx   <= i_rule_index;
            r_a_mask  <= i_rule_mask;
            r_a_shift <= i_rule_shift;
            r_a_left  <= i_rule_left;
        end
        if (rdy_b) begin
            r_b_op    <= r_a_op;
            r_b_word  <= n_prep;
            r_b_idx   <= r_a_idx;
            r_b_mask  <= r_a_mask;
            r_b_shift <= r_a_shift;
            r_b_left  <= r_a_left;
        end
        if (rdy_c) begin
            r_c_word <= r_b_word;
            for (int i = 0; i < pbrgt_pkg::MAX_RULES; i++) begin
                r_c_lane[i] <= n_lane[i];
            end
        end
        if (rdy_d) begin
            r_d_word <= r_c_word;
            for (int g = 0; g < pbrgt_pkg::N_GRP; g++) begin
                r_d_grp[g] <= n_grp[g];
            end
        end
        if (rdy_e) begin
            r_e_word <= n_word;
        end
    end

    // rule table, slots past the table size are never matched
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < pbrgt_pkg::MAX_RULES; i++) begin
            if (tbl_wr && (pbrgt_pkg::LANE_CMP_W'(r_b_idx) == pbrgt_pkg::LANE_CMP_W'(i))) begin
                r_rule_mask[i]  <= r_b_mask;
                r_rule_shift[i] <= r_b_shift;
                r_rule_left[i]  <= r_b_left;
            end
        end
    end

endmodule

// ===== test/pixel_word_checker.sv =====
module pixel_word_checker
    import pbrgt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_operation,
    input  logic [PIX_W-1:0]     i_pixel_rgb,
    input  logic [IDX_W-1:0]     i_rule_index,
    input  logic [WORD_W-1:0]    i_rule_mask,
    input  logic [SHIFT_W-1:0]   i_rule_shift,
    input  logic                 i_rule_left,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [WORD_W-1:0]    i_pixel_word,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic [WORD_W-1:0]  mask;
        logic [SHIFT_W-1:0] shift;
        logic               left;
    } t_remap_rule;

    // luma weights, sum divided by 32
    localparam int WEIGHT_RED   = 11;
    localparam int WEIGHT_GREEN = 16;
    localparam int WEIGHT_BLUE  = 5;

    logic [1:0]        mode_r;
    logic [THR_W-1:0]  thr_r;
    logic [CNT_W-1:0]  count_r;
    logic [WORD_W-1:0] and_r;
    logic [WORD_W-1:0] or_r;
    t_remap_rule       rules [MAX_RULES];

    logic [WORD_W-1:0] pending_words [$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [CHAN_W-1:0] gray_level(input logic [PIX_W-1:0] rgb);
        int sum;
        sum = int'(rgb[23:16]) * WEIGHT_RED + int'(rgb[15:8]) * WEIGHT_GREEN
            + int'(rgb[7:0]) * WEIGHT_BLUE;
        return CHAN_W'(sum >> 5);
    endfunction

    function automatic logic [WORD_W-1:0] remap_pixel(input logic [PIX_W-1:0] rgb);
        logic [CHAN_W-1:0] gray;
        logic [WORD_W-1:0] prepared;
        logic [WORD_W-1:0] sel;
        logic [WORD_W-1:0] acc;
        int                n;
        gray = gray_level(rgb);
        case (mode_r)
            MODE_GRAY: prepared = {8'h00, gray, gray, gray};
            MODE_MONO: prepared = (gray < thr_r) ? {8'h00, PIX_BLACK} : {8'h00, PIX_WHITE};
            default:   prepared = {8'h00, rgb};
        endcase
        // rule count saturates at the table size
        n = (int'(count_r) > MAX_RULES) ? MAX_RULES : int'(count_r);
        if (n == 0) begin
            acc = prepared;
        end else begin
            acc = '0;
            for (int i = 0; i < n; i++) begin
                sel = prepared & rules[i].mask;
                if (rules[i].left) begin
                    acc |= sel << rules[i].shift;
                end else begin
                    acc |= sel >> rules[i].shift;
                end
            end
        end
        return (acc & and_r) | or_r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("[%0t] pixel_word mismatch (%s): expected %08h, got %08h",
                 $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            mode_r  = MODE_COLOR;
            thr_r   = RST_THR;
            count_r = '0;
            and_r   = RST_AND;
            or_r    = RST_OR;
            for (int i = 0; i < MAX_RULES; i++) begin
                rules[i] = '0;
            end
            pending_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("no pixel pending", '0, i_pixel_word);
                end else begin
                    want = pending_words.pop_front();
                    if (want !== i_pixel_word) begin
                        report_mismatch("pixel_word", want, i_pixel_word);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COLOR_MODE: mode_r  = i_cfg_wdata[1:0];
                    CFG_THRESHOLD:  thr_r   = i_cfg_wdata[THR_W-1:0];
                    CFG_RULE_COUNT: count_r = i_cfg_wdata[CNT_W-1:0];
                    CFG_AND_MASK:   and_r   = i_cfg_wdata;
                    CFG_OR_MASK:    or_r    = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_LOAD) begin
                    if (int'(i_rule_index) < MAX_RULES) begin
                        rules[i_rule_index] = '{i_rule_mask, i_rule_shift, i_rule_left};
                    end
                end else begin
                    pending_words.push_back(remap_pixel(i_pixel_rgb));
                end
            end
        end
        o_pending <= pending_words.size();
    end

endmodule

// ===== test/tb_pixel_bit_remap_with_gray_threshold.sv =====
module tb_pixel_bit_remap_with_gray_threshold;
    import pbrgt_pkg::*;

    // stimulus size and pacing
    localparam int N_ITEMS      = 1750;
    localparam int CALM_FROM    = 1500;   // no idling on either side past this many items
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 12;     // pipeline is 5 deep, loads leave no result
    // cycles with no transfer on either channel before giving up
    localparam int STALL_LIMIT  = 2000;

    // register codes and values with no package name
    localparam logic [1:0]           MODE_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_OR_MASK + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = {CFG_IDX_W{1'b1}};
    localparam logic [CNT_W-1:0]     COUNT_TOP       = {CNT_W{1'b1}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_operation;
    logic [PIX_W-1:0]     i_pixel_rgb;
    logic [IDX_W-1:0]     i_rule_index;
    logic [WORD_W-1:0]    i_rule_mask;
    logic [SHIFT_W-1:0]   i_rule_shift;
    logic                 i_rule_left;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [WORD_W-1:0]    o_pixel_word;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_wdata;

    int               pending;
    int               fail_count;
    int               idle_cycles = 0;
    int               ready_hold = 0;
    int               gap_odds = 0;     // percent chance of a sender gap after a transfer
    int               sent = 0;
    bit               calm = 1'b0;
    logic [CNT_W-1:0] count_now = '0;   // rule count as last written
    bit               slot_written [MAX_RULES];

    pixel_bit_remap_with_gray_threshold dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_pixel_rgb  (i_pixel_rgb),
        .i_rule_index (i_rule_index),
        .i_rule_mask  (i_rule_mask),
        .i_rule_shift (i_rule_shift),
        .i_rule_left  (i_rule_left),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_word (o_pixel_word),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // predicts every pixel word and compares it on the output transfer
    pixel_word_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_pixel_rgb  (i_pixel_rgb),
        .i_rule_index (i_rule_index),
        .i_rule_mask  (i_rule_mask),
        .i_rule_shift (i_rule_shift),
        .i_rule_left  (i_rule_left),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_pixel_word (o_pixel_word),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // output side: stall bursts and ready stretches in random order, always ready once calm
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(1, MAX_GAP) - 1;
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 39);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("pixel_bit_remap_with_gray_threshold test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transfer, then maybe a sender gap
    task automatic send_item(input t_op op, input logic [PIX_W-1:0] rgb,
                             input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] mask,
                             input logic [SHIFT_W-1:0] shift, input logic left);
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_pixel_rgb  <= rgb;
        i_rule_index <= idx;
        i_rule_mask  <= mask;
        i_rule_shift <= shift;
        i_rule_left  <= left;
        if (op == OP_LOAD) begin
            slot_written[idx] = 1'b1;
        end
        sent++;
        calm = (sent >= CALM_FROM);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 99) < gap_odds) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
    endtask

    // unused rule fields carry noise on pixel transfers
    task automatic send_pixel(input logic [PIX_W-1:0] rgb);
        send_item(OP_PIXEL, rgb, IDX_W'($urandom()), $urandom(), SHIFT_W'($urandom()),
                  1'($urandom()));
    endtask

    task automatic send_rule(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] mask,
                             input logic [SHIFT_W-1:0] shift, input logic left);
        send_item(OP_LOAD, PIX_W'($urandom()), idx, mask, shift, left);
    endtask

    // leaves the write enable high, the caller lowers it after the batch
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_RULE_COUNT) begin
            count_now = data[CNT_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // noise above the field width of the narrow registers
    task automatic configure(input logic [1:0] mode, input logic [THR_W-1:0] thr,
                             input logic [CNT_W-1:0] count, input logic [WORD_W-1:0] and_m,
                             input logic [WORD_W-1:0] or_m);
        cfg_write(CFG_COLOR_MODE, {30'($urandom()), mode});
        cfg_write(CFG_THRESHOLD, {24'($urandom()), thr});
        cfg_write(CFG_RULE_COUNT, {26'($urandom()), count});
        cfg_write(CFG_AND_MASK, and_m);
        cfg_write(CFG_OR_MASK, or_m);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom());
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // wait until every pixel word is back and the pipeline is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            3:       return {8'h00, PIX_W'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_rgb();
        logic [CHAN_W-1:0] level;
        level = CHAN_W'($urandom());
        case ($urandom_range(0, 9))
            0:       return PIX_BLACK;
            1:       return PIX_WHITE;
            2:       return {level, level, level};
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // active rules are always loaded before any pixel reads them
    task automatic fill_active_slots();
        int n;
        n = (int'(count_now) > MAX_RULES) ? MAX_RULES : int'(count_now);
        for (int i = 0; i < n; i++) begin
            if (!slot_written[i]) begin
                send_rule(IDX_W'(i), pick_mask(), SHIFT_W'($urandom()), 1'($urandom()));
            end
        end
    endtask

    task automatic random_phase();
        logic [1:0]        mode;
        logic [THR_W-1:0]  thr;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] and_m;
        logic [WORD_W-1:0] or_m;
        int                len;
        mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       thr = '0;
            1:       thr = '1;
            default: thr = THR_W'($urandom());
        endcase
        case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = CNT_W'(1);
            2:       count = CNT_W'(MAX_RULES);
            3:       count = CNT_W'($urandom_range(MAX_RULES + 1, COUNT_TOP));
            default: count = CNT_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 19))
            0:       and_m = '0;
            1, 2:    and_m = $urandom();
            default: and_m = RST_AND;
        endcase
        case ($urandom_range(0, 19))
            0:       or_m = '1;
            1, 2:    or_m = $urandom();
            default: or_m = RST_OR;
        endcase
        settle();
        configure(mode, thr, count, and_m, or_m);
        fill_active_slots();
        // some phases run without sender gaps
        gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 25;
        len = $urandom_range(40, 120);
        for (int i = 0; i < len && sent < N_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_rule(IDX_W'($urandom()), pick_mask(), SHIFT_W'($urandom()),
                          1'($urandom()));
            end else begin
                send_pixel(pick_rgb());
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= OP_PIXEL;
        i_pixel_rgb  <= '0;
        i_rule_index <= '0;
        i_rule_mask  <= '0;
        i_rule_shift <= '0;
        i_rule_left  <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= CFG_COLOR_MODE;
        i_cfg_wdata  <= '0;
        for (int i = 0; i < MAX_RULES; i++) begin
            slot_written[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: color passthrough, no rules, open masks
        send_pixel(PIX_BLACK);
        send_pixel(PIX_WHITE);
        send_pixel(24'h123456);

        // identity rule, left shift past bit 31, full right shift, last table slot
        send_rule(IDX_W'(0), '1, SHIFT_W'(0), 1'b1);
        send_rule(IDX_W'(1), 32'h0000_ffff, SHIFT_W'(31), 1'b1);
        send_rule(IDX_W'(2), 32'hffff_0000, SHIFT_W'(31), 1'b0);
        send_rule(IDX_W'(MAX_RULES - 1), '1, SHIFT_W'(16), 1'b0);

        // grayscale on the pure channels
        settle();
        configure(MODE_GRAY, RST_THR, CNT_W'(3), RST_AND, RST_OR);
        send_pixel(PIX_WHITE);
        send_pixel(PIX_BLACK);
        send_pixel(24'hff0000);
        send_pixel(24'h00ff00);
        send_pixel(24'h0000ff);

        // monochrome at the top threshold: only full white stays white
        settle();
        configure(MODE_MONO, '1, CNT_W'(1), RST_AND, RST_OR);
        send_pixel(24'h808080);
        send_pixel(PIX_WHITE);
        send_pixel(24'hfefefe);

        // monochrome at zero threshold, nothing is black, then the masks
        settle();
        configure(MODE_MONO, '0, CNT_W'(0), 32'h0000_ffff, 32'hff00_0000);
        send_pixel(PIX_BLACK);

        // unused color mode passes the pixel through
        settle();
        configure(MODE_SPARE, RST_THR, CNT_W'(0), RST_AND, RST_OR);
        send_pixel(24'ha5c3e1);

        while (sent < N_ITEMS) begin
            random_phase();
        end

        calm = 1'b1;
        settle();
        if (fail_count == 0) begin
            $display("pixel_bit_remap_with_gray_threshold test passed");
        end else begin
            $display("pixel_bit_remap_with_gray_threshold test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/pbrgt_pkg.sv
src/pixel_bit_remap_with_gray_threshold.sv
test/pixel_word_checker.sv
test/tb_pixel_bit_remap_with_gray_threshold.sv
